// ===== rtl/core/lirs_pkg.sv =====
// ----------------------------------------------------------------------------
// lirs_pkg: shared types and constants of the linear interpolation resampler
// Register widths, controller states and the command/status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package lirs_pkg;

  // step ratio register width (unsigned fixed point)
  localparam int RATIO_W = 24;
  // read phase width: holds phase below one plus the largest step
  localparam int PHASE_W = RATIO_W + 1;
  // longest run of results for one input sample
  localparam int MAX_RUN = 64;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_MUL,
    ST_OUT
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic cap_in;      // capture the accepted input sample
    logic prev_load;   // previous sample takes the captured sample
    logic phase_wrap;  // phase drops by one (input skipped)
    logic mul_en;      // register the difference products
    logic out_load;    // load the output register
    logic out_bypass;  // output register takes the captured sample as is
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic bypass;        // ratio is exactly one
    logic phase_ge_one;  // current phase is at or above one
    logic sum_ge_one;    // phase plus step reaches one: this result ends the run
    logic out_free;      // output register can take a new result this cycle
  } dp_stat_t;

endpackage

// ===== rtl/core/lirs_if.sv =====
// ----------------------------------------------------------------------------
// lirs_in_if / lirs_out_if: sample channels of the resampler
// Valid/ready channels; a transaction completes when valid and ready are high.
// ----------------------------------------------------------------------------
interface lirs_in_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] in_left;
  logic signed [SAMPLE_BITS-1:0] in_right;

  modport source (output valid, output in_left, output in_right, input ready);
  modport sink (input valid, input in_left, input in_right, output ready);
endinterface

interface lirs_out_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_left;
  logic signed [SAMPLE_BITS-1:0] out_right;
  logic                          last_of_run;

  modport source (output valid, output out_left, output out_right,
                  output last_of_run, input ready);
  modport sink (input valid, input out_left, input out_right,
                input last_of_run, output ready);
endinterface

// ===== rtl/core/lirs_ctrl.sv =====
// ----------------------------------------------------------------------------
// lirs_ctrl: resampler sequencer
// Decides per input sample between bypass, priming, skipping and an
// interpolation run, and steps the datapath through the run.
// ----------------------------------------------------------------------------
module lirs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lirs_pkg::dp_stat_t stat,
  output lirs_pkg::dp_cmd_t  cmd
);
  import lirs_pkg::*;

  state_t state_r, state_nxt;
  logic   primed_r, primed_nxt;

  // state and primed flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      primed_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      primed_r <= primed_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    primed_nxt = primed_r;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap_in = 1'b1;
          state_nxt  = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (stat.bypass) begin
          // pass through once the output register is free
          if (stat.out_free) begin
            cmd.prev_load  = 1'b1;
            cmd.out_load   = 1'b1;
            cmd.out_bypass = 1'b1;
            primed_nxt     = 1'b1;
            state_nxt      = ST_IDLE;
          end
        end else if (!primed_r) begin
          cmd.prev_load = 1'b1;
          primed_nxt    = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (stat.phase_ge_one) begin
          // downsampling: skip this input
          cmd.prev_load  = 1'b1;
          cmd.phase_wrap = 1'b1;
          state_nxt      = ST_IDLE;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          if (stat.sum_ge_one) begin
            cmd.prev_load = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            state_nxt = ST_MUL;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/lirs_dp.sv =====
// ----------------------------------------------------------------------------
// lirs_dp: resampler datapath
// Holds ratio, phase and samples, forms prev + floor((cur - prev) * frac)
// with one registered multiplier per channel, and owns the output register.
// ----------------------------------------------------------------------------
module lirs_dp #(
  parameter int CHANNELS        = 2,
  parameter int SAMPLE_BITS     = 16,
  parameter int PHASE_FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [lirs_pkg::RATIO_W-1:0]     cfg_wdata,
  input  logic signed [SAMPLE_BITS-1:0]    in_left,
  input  logic signed [SAMPLE_BITS-1:0]    in_right,
  input  lirs_pkg::dp_cmd_t                cmd,
  output lirs_pkg::dp_stat_t               stat,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [SAMPLE_BITS-1:0]    out_left,
  output logic signed [SAMPLE_BITS-1:0]    out_right,
  output logic                             out_last
);
  import lirs_pkg::*;

  localparam int PROD_W = SAMPLE_BITS + PHASE_FRAC_BITS + 2;
  localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1) << PHASE_FRAC_BITS;
  localparam logic [RATIO_W-1:0] MIN_STEP  = RATIO_W'(1) << (PHASE_FRAC_BITS - 6);

  logic [RATIO_W-1:0]            ratio_r;
  logic [PHASE_W-1:0]            phase_r, phase_nxt;
  logic signed [SAMPLE_BITS-1:0] cur_l_r, cur_r_r;
  logic signed [SAMPLE_BITS-1:0] prev_l_r, prev_r_r;
  logic signed [PROD_W-1:0]      prod_l_r, prod_r_r;
  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] out_l_r, out_r_r;
  logic                          out_last_r;

  logic [RATIO_W-1:0]            step;
  logic [PHASE_W-1:0]            phase_sum;
  logic signed [SAMPLE_BITS:0]   diff_l, diff_r;
  logic signed [PHASE_FRAC_BITS:0] frac_s;
  logic signed [PROD_W-1:0]      q_l, q_r;
  logic signed [SAMPLE_BITS:0]   res_l, res_r;

  // step with the lower clamp, next phase candidate
  assign step      = (ratio_r < MIN_STEP) ? MIN_STEP : ratio_r;
  assign phase_sum = phase_r + {1'b0, step};

  // status toward the controller
  assign stat.bypass       = ({1'b0, ratio_r} == PHASE_ONE);
  assign stat.phase_ge_one = (phase_r >= PHASE_ONE);
  assign stat.sum_ge_one   = (phase_sum >= PHASE_ONE);
  assign stat.out_free     = !out_valid_r || out_ready;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r <= PHASE_ONE[RATIO_W-1:0];
    end else if (cfg_we) begin
      ratio_r <= cfg_wdata;
    end
  end

  // phase update: skip wraps, each result steps, last result wraps too
  always_comb begin
    phase_nxt = phase_r;
    if (cmd.phase_wrap) begin
      phase_nxt = phase_r - PHASE_ONE;
    end else if (cmd.out_load && !cmd.out_bypass) begin
      phase_nxt = stat.sum_ge_one ? (phase_sum - PHASE_ONE) : phase_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= '0;
      prev_l_r <= '0;
      prev_r_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      if (cmd.prev_load) begin
        prev_l_r <= cur_l_r;
        prev_r_r <= cur_r_r;
      end
    end
  end

  // input capture; right channel is zero for mono
  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      cur_l_r <= in_left;
      cur_r_r <= (CHANNELS == 1) ? '0 : in_right;
    end
  end

  // difference times fractional phase, registered
  assign diff_l = {cur_l_r[SAMPLE_BITS-1], cur_l_r} - {prev_l_r[SAMPLE_BITS-1], prev_l_r};
  assign diff_r = {cur_r_r[SAMPLE_BITS-1], cur_r_r} - {prev_r_r[SAMPLE_BITS-1], prev_r_r};
  assign frac_s = $signed({1'b0, phase_r[PHASE_FRAC_BITS-1:0]});

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_l_r <= PROD_W'(diff_l * frac_s);
      prod_r_r <= PROD_W'(diff_r * frac_s);
    end
  end

  // floor by arithmetic shift, then add to prev; result lies between samples
  assign q_l   = prod_l_r >>> PHASE_FRAC_BITS;
  assign q_r   = prod_r_r >>> PHASE_FRAC_BITS;
  assign res_l = {prev_l_r[SAMPLE_BITS-1], prev_l_r} + q_l[SAMPLE_BITS:0];
  assign res_r = {prev_r_r[SAMPLE_BITS-1], prev_r_r} + q_r[SAMPLE_BITS:0];

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_l_r    <= cmd.out_bypass ? cur_l_r : res_l[SAMPLE_BITS-1:0];
      out_r_r    <= cmd.out_bypass ? cur_r_r : res_r[SAMPLE_BITS-1:0];
      out_last_r <= cmd.out_bypass | stat.sum_ge_one;
    end
  end

  assign out_valid = out_valid_r;
  assign out_left  = out_l_r;
  assign out_right = out_r_r;
  assign out_last  = out_last_r;

endmodule

// ===== rtl/core/linear_interp_resampler_core.sv =====
// ----------------------------------------------------------------------------
// linear_interp_resampler_core: linear interpolation sample rate converter
// Takes one stereo sample per input transaction and emits zero or more
// interpolated samples between the previous and the current one.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  : valid/ready sample input (in_left, in_right).
//   out_if : valid/ready result output (out_left, out_right, last_of_run);
//            last_of_run marks the final result caused by an input sample.
//   cfg_we/cfg_wdata : step ratio write, unsigned fixed point with
//            PHASE_FRAC_BITS fraction bits; write it only while idle.
// Timing: an accepted sample is decided in the following cycle. Priming and skipped
//   inputs then return to idle; bypass waits for a free output register. An
//   interpolation run takes a multiplier state, then the add into the output
//   register, per result, and waits while that register is stalled; a run holds
//   at most MAX_RUN results. The per-channel multiplier is the paced unit.
// Reset: ratio returns to one (bypass), phase and history samples clear, the first
//   non-bypass sample only primes the history.
// Stall: the output register holds its result while out_if.ready is low; the
//   run waits on it, and a new input is taken as soon as the run is done even
//   if its last result is still waiting.
// ----------------------------------------------------------------------------
module linear_interp_resampler_core #(
  parameter int CHANNELS        = 2,
  parameter int SAMPLE_BITS     = 16,
  parameter int PHASE_FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  lirs_in_if.sink                      in_if,
  lirs_out_if.source                   out_if,
  input  logic                         cfg_we,
  input  logic [lirs_pkg::RATIO_W-1:0] cfg_wdata
);
  import lirs_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  lirs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // arithmetic and storage
  lirs_dp #(
    .CHANNELS        (CHANNELS),
    .SAMPLE_BITS     (SAMPLE_BITS),
    .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_left   (in_if.in_left),
    .in_right  (in_if.in_right),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_left  (out_if.out_left),
    .out_right (out_if.out_right),
    .out_last  (out_if.last_of_run)
  );

endmodule

// ===== rtl/core/lirs_chk.sv =====
// ----------------------------------------------------------------------------
// lirs_chk: port-level checks of the resampler
// Watches the channels of the top level; attached by bind.
// ----------------------------------------------------------------------------
module lirs_chk #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] out_left,
  input logic [SAMPLE_BITS-1:0] out_right,
  input logic                   out_last
);

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // an accepted sample is decided before the next one is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after a transaction");

  // a stalled result stays offered
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("output valid dropped while stalled");

  // a stalled result keeps its payload
  a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      ($stable(out_left) && $stable(out_right) && $stable(out_last)))
    else $error("output payload changed while stalled");

endmodule

bind linear_interp_resampler_core lirs_chk #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_lirs_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_left  (out_if.out_left),
  .out_right (out_if.out_right),
  .out_last  (out_if.last_of_run)
);

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for linear_interp_resampler_core
// Drives stereo samples through the valid/ready input channel and programs
// the step ratio while the core is idle. A bit-exact predictor of the
// interpolation builds the expected results per accepted transaction, and
// every output transaction is checked field by field against them.
// ----------------------------------------------------------------------------
module tb;
  import lirs_pkg::*;

  localparam int SAMPLE_W     = 16;
  localparam int FRAC_BITS    = 16;
  localparam int UNITY        = 1 << FRAC_BITS;
  localparam int MIN_STEP     = 1 << (FRAC_BITS - 6);
  localparam int RATIO_MAX    = (1 << RATIO_W) - 1;
  localparam int RANDOM_ITEMS = 375;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 5_000_000;

  typedef logic signed [SAMPLE_W-1:0] pcm_t;

  typedef struct packed {
    pcm_t left;
    pcm_t right;
    logic last;
  } resampled_t;

  localparam pcm_t PCM_MAX = 16'sh7FFF;
  localparam pcm_t PCM_MIN = 16'sh8000;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [RATIO_W-1:0] cfg_wdata;

  lirs_in_if  #(.SAMPLE_BITS(SAMPLE_W)) in_ch ();
  lirs_out_if #(.SAMPLE_BITS(SAMPLE_W)) out_ch ();

  linear_interp_resampler_core #(
    .CHANNELS        (2),
    .SAMPLE_BITS     (SAMPLE_W),
    .PHASE_FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state
  logic [RATIO_W-1:0] ratio_m;
  pcm_t               hist_l;
  pcm_t               hist_r;
  logic [PHASE_W-1:0] phase_m;
  logic               primed_m;

  resampled_t resampled_q[$];
  int         mismatches   = 0;
  int         cycle_cnt    = 0;
  bit         gaps_on      = 1'b1;
  bit         stalls_on    = 1'b1;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ------------------------------------------------------------------------
  // prediction
  // ------------------------------------------------------------------------

  // prev + floor((cur - prev) * phase / 2^FRAC_BITS)
  function automatic pcm_t lerp(pcm_t a, pcm_t b, logic [PHASE_W-1:0] ph);
    longint diff;
    longint prod;
    pcm_t   res;
    diff = longint'(b) - longint'(a);
    prod = diff * longint'({1'b0, ph});
    res  = pcm_t'(longint'(a) + (prod >>> FRAC_BITS));
    return res;
  endfunction

  // expected results for one accepted input transaction
  function automatic void resample_input(pcm_t cur_l, pcm_t cur_r);
    logic [PHASE_W-1:0] step;
    resampled_t         r;
    int                 n;
    if (ratio_m == UNITY) begin
      // bypass: pass through, phase untouched
      r.left  = cur_l;
      r.right = cur_r;
      r.last  = 1'b1;
      resampled_q.push_back(r);
    end else if (primed_m) begin
      step = (ratio_m < MIN_STEP) ? PHASE_W'(MIN_STEP) : PHASE_W'(ratio_m);
      n = 0;
      while (phase_m < UNITY && n < MAX_RUN) begin
        r.left  = lerp(hist_l, cur_l, phase_m);
        r.right = lerp(hist_r, cur_r, phase_m);
        r.last  = (phase_m + step >= UNITY) || (n == MAX_RUN - 1);
        resampled_q.push_back(r);
        phase_m = phase_m + step;
        n++;
      end
      // also covers an input skipped because the phase was already past one
      if (phase_m >= UNITY)
        phase_m = phase_m - PHASE_W'(UNITY);
    end
    // priming, bypass, skips and runs all leave the sample as history
    hist_l   = cur_l;
    hist_r   = cur_r;
    primed_m = 1'b1;
  endfunction

  // compare one output transaction with the oldest expectation
  function automatic void check_result();
    resampled_t exp_r;
    if (resampled_q.size() == 0) begin
      $error("unexpected result: out_left %0d out_right %0d last_of_run %0b",
             out_ch.out_left, out_ch.out_right, out_ch.last_of_run);
      mismatches++;
    end else begin
      exp_r = resampled_q.pop_front();
      if (out_ch.out_left !== exp_r.left) begin
        $error("out_left: expected %0d, got %0d", exp_r.left, out_ch.out_left);
        mismatches++;
      end
      if (out_ch.out_right !== exp_r.right) begin
        $error("out_right: expected %0d, got %0d", exp_r.right, out_ch.out_right);
        mismatches++;
      end
      if (out_ch.last_of_run !== exp_r.last) begin
        $error("last_of_run: expected %0b, got %0b", exp_r.last, out_ch.last_of_run);
        mismatches++;
      end
    end
  endfunction

  // monitor: sample both channels and the config port at the rising edge
  always @(posedge clk) begin
    cycle_cnt = cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else if (!rst_n) begin
      ratio_m  = RATIO_W'(UNITY);
      hist_l   = '0;
      hist_r   = '0;
      phase_m  = '0;
      primed_m = 1'b0;
    end else begin
      // results always belong to earlier inputs, so check before predicting
      if (out_ch.valid && out_ch.ready)
        check_result();
      if (cfg_we)
        ratio_m = cfg_wdata;
      if (in_ch.valid && in_ch.ready)
        resample_input(in_ch.in_left, in_ch.in_right);
    end
  end

  // ------------------------------------------------------------------------
  // drivers
  // ------------------------------------------------------------------------

  // idle length: mostly none, some short, a few long
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60)
      return 0;
    else if (pick < 92)
      return $urandom_range(1, 3);
    else
      return $urandom_range(8, 40);
  endfunction

  // output back-pressure
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!stalls_on || $urandom_range(0, 3) != 0) begin
        out_ch.ready = 1'b1;
      end else begin
        out_ch.ready = 1'b0;
        repeat (idle_len()) @(negedge clk);
      end
    end
  end

  // one input transaction; starts and ends at a falling edge, valid left high
  task automatic send_sample(input pcm_t l, input pcm_t r);
    int gap;
    gap = gaps_on ? idle_len() : 0;
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid    = 1'b1;
    in_ch.in_left  = l;
    in_ch.in_right = r;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // drop valid, wait for every expected result, then let the core settle
  task automatic wait_idle();
    in_ch.valid = 1'b0;
    while (resampled_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_ratio(input logic [RATIO_W-1:0] value);
    cfg_wdata = value;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  function automatic pcm_t pick_sample(pcm_t near);
    pcm_t v;
    case ($urandom_range(0, 9))
      0:       v = PCM_MAX;
      1:       v = PCM_MIN;
      2, 3, 4, 5: v = pcm_t'($urandom);
      default: v = pcm_t'(near + $urandom_range(0, 4095) - 2048);
    endcase
    return v;
  endfunction

  function automatic logic [RATIO_W-1:0] pick_ratio();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 2)
      return RATIO_W'(UNITY);
    else if (pick < 4)
      return RATIO_W'($urandom_range(0, MIN_STEP - 1));
    else if (pick < 10)
      return RATIO_W'($urandom_range(MIN_STEP, UNITY - 1));
    else if (pick < 14)
      return RATIO_W'($urandom_range(UNITY + 1, 4 * UNITY));
    else if (pick < 16)
      return RATIO_W'(UNITY + $urandom_range(0, 63) - 32);
    else if (pick < 18)
      return RATIO_W'($urandom_range(UNITY, 1 << 20));
    else if (pick < 19)
      return RATIO_W'($urandom_range(0, RATIO_MAX));
    else
      return RATIO_W'(MIN_STEP);
  endfunction

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------

  // first sample after reset outside bypass only loads the history
  task automatic test_priming();
    write_ratio(RATIO_W'(UNITY / 2));
    send_sample(PCM_MAX, PCM_MIN);
    send_sample(PCM_MIN, PCM_MAX);
    send_sample(-16'sd1, 16'sd1);
    send_sample(16'sd0, 16'sd0);
  endtask

  // unity ratio passes samples straight through
  task automatic test_bypass();
    wait_idle();
    write_ratio(RATIO_W'(UNITY));
    send_sample(PCM_MAX, PCM_MIN);
    send_sample(PCM_MIN, PCM_MAX);
    send_sample(16'sd0, -16'sd1);
  endtask

  // ratios below 1/64 are clamped: full 64-result runs
  task automatic test_min_ratio();
    wait_idle();
    write_ratio('0);
    send_sample(PCM_MIN, PCM_MAX);
    send_sample(PCM_MAX, PCM_MIN);
    wait_idle();
    write_ratio(RATIO_W'(MIN_STEP - 1));
    send_sample(16'sd12345, -16'sd12345);
    wait_idle();
    write_ratio(RATIO_W'(MIN_STEP));
    send_sample(-16'sd1, 16'sd0);
  endtask

  // ratios above one skip inputs, and one just below one; end with the largest ratio
  task automatic test_downsample();
    wait_idle();
    write_ratio(RATIO_W'(UNITY + 1));
    send_sample(PCM_MAX, PCM_MAX);
    send_sample(PCM_MIN, PCM_MIN);
    send_sample(16'sd100, -16'sd100);
    wait_idle();
    write_ratio(RATIO_W'(2 * UNITY));
    send_sample(16'sd7, -16'sd7);
    send_sample(PCM_MIN, PCM_MAX);
    send_sample(16'sd0, 16'sd1);
    wait_idle();
    write_ratio(RATIO_W'(UNITY - 1));
    send_sample(-16'sd2, 16'sd3);
    send_sample(PCM_MAX, PCM_MIN);
    wait_idle();
    write_ratio(RATIO_W'(RATIO_MAX));
    send_sample(16'sd1, 16'sd1);
    send_sample(PCM_MIN, PCM_MAX);
    send_sample(PCM_MAX, PCM_MIN);
    send_sample(16'sd0, 16'sd0);
  endtask

  // random ratios per phase, random samples, random idling
  task automatic test_random_ratios();
    int   sent;
    int   len;
    pcm_t l;
    pcm_t r;
    sent = 0;
    l    = '0;
    r    = '0;
    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      write_ratio(pick_ratio());
      gaps_on   = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      len = $urandom_range(8, 40);
      repeat (len) begin
        l = pick_sample(l);
        r = pick_sample(r);
        send_sample(l, r);
        sent++;
      end
    end
  endtask

  // ------------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------------
  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_ch.valid    = 1'b0;
    in_ch.in_left  = '0;
    in_ch.in_right = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_priming();
    test_bypass();
    test_min_ratio();
    test_downsample();
    test_random_ratios();
    wait_idle();

    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
